// File: rtl/core/acstc_pkg.sv
package acstc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CFG_WIDTH    = 16;

    // Register indexes on the configuration port
    localparam logic CFG_LOSS_TIMEOUT = 1'b0;
    localparam logic CFG_BEEP_TICKS   = 1'b1;

    localparam logic [CFG_WIDTH-1:0] DEFAULT_TICKS = 16'd100;

    // Selection code for "no source among channels 1 to 3"
    localparam logic [1:0] NO_SOURCE = 2'd3;

    typedef logic [NUM_CHANNELS-1:0] chan_mask_t;

endpackage

// File: rtl/core/ac_source_transfer_controller_unit.sv
// AC source transfer controller. Each request is one millisecond tick carrying the
// rising edges seen by four AC detector channels; each tick yields exactly one result
// (relay drive, presence, selected source, buzzer). One request is taken per clock
// cycle whenever the result side keeps up: the whole per-tick update is a single pass
// of shallow logic from the state registers into the state and result registers, so
// a result shows in the cycle after its request is taken. The result
// register frees as it is taken, so a new request is accepted in the same cycle the
// previous result leaves. A channel turns present on an edge and absent once its age
// counter exceeds loss_timeout; ages saturate at 2**AGE_WIDTH-1, so a loss_timeout at
// or above that value never expires. Relay 4 follows channel 4. Relays 1 to 3 follow
// a sticky selection: all three present forces source 1; with nothing selected, the
// lowest present source is taken and a beep of beep_ticks ticks starts unless one is
// sounding; a lost source is released and relays 1 to 3 stay off for that tick.
// Write configuration only while no tick is in flight.
module ac_source_transfer_controller_unit #(
    parameter int AGE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [acstc_pkg::CFG_WIDTH-1:0] cfg_wdata,
    // tick requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_edge_mask,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_relay_drive,
    output logic [3:0]                    m_source_present,
    output logic [1:0]                    m_selected_source,
    output logic                          m_buzzer_on
);

    // Width used to compare an age against the 16 bit timeout
    localparam int CMP_WIDTH = (AGE_WIDTH > acstc_pkg::CFG_WIDTH) ? AGE_WIDTH
                                                                  : acstc_pkg::CFG_WIDTH;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // Configuration registers
    logic [acstc_pkg::CFG_WIDTH-1:0] loss_timeout_reg;
    logic [acstc_pkg::CFG_WIDTH-1:0] beep_ticks_reg;

    // Tick state
    acstc_pkg::chan_mask_t           present_reg, present_next;
    logic [AGE_WIDTH-1:0]            age_reg  [acstc_pkg::NUM_CHANNELS];
    logic [AGE_WIDTH-1:0]            age_next [acstc_pkg::NUM_CHANNELS];
    logic [1:0]                      selection_reg, selection_next;
    logic                            beep_active_reg, beep_active_next;
    logic [acstc_pkg::CFG_WIDTH-1:0] beep_left_reg, beep_left_next;

    // Result register
    logic                            m_valid_reg;
    logic [3:0]                      relay_reg, relay_next;

    logic s_accept;

    // The result slot is free when empty or being taken this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_timeout_reg <= acstc_pkg::DEFAULT_TICKS;
            beep_ticks_reg   <= acstc_pkg::DEFAULT_TICKS;
        end else if (cfg_we) begin
            case (cfg_index)
                acstc_pkg::CFG_LOSS_TIMEOUT: loss_timeout_reg <= cfg_wdata;
                acstc_pkg::CFG_BEEP_TICKS:   beep_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic                            lost;
        logic [acstc_pkg::CFG_WIDTH-1:0] left_dec;
        logic                            start_beep;

        present_next = present_reg;
        relay_next   = '0;
        start_beep   = 1'b0;

        // Advance ages, restart on an edge, then apply the loss timeout
        for (int i = 0; i < acstc_pkg::NUM_CHANNELS; i++) begin
            age_next[i] = (age_reg[i] != AGE_MAX) ? age_reg[i] + 1'b1 : age_reg[i];
            if (s_edge_mask[i]) begin
                age_next[i]     = '0;
                present_next[i] = 1'b1;
            end
            if (CMP_WIDTH'(age_next[i]) > CMP_WIDTH'(loss_timeout_reg)) begin
                present_next[i] = 1'b0;
            end
        end

        // Count down a running beep
        left_dec = (beep_active_reg && beep_left_reg != '0) ? beep_left_reg - 1'b1
                                                            : beep_left_reg;

        // Relay 4 follows channel 4 directly
        relay_next[3] = present_next[3];

        // Sticky selection among channels 1 to 3
        selection_next = selection_reg;
        lost           = 1'b0;
        if (present_next[2:0] == 3'b111) begin
            selection_next = 2'd0;
            relay_next[0]  = 1'b1;
        end else if (selection_reg == acstc_pkg::NO_SOURCE) begin
            if (present_next[0]) begin
                selection_next = 2'd0;
                relay_next[0]  = 1'b1;
                start_beep     = 1'b1;
            end else if (present_next[1]) begin
                selection_next = 2'd1;
                relay_next[1]  = 1'b1;
                start_beep     = 1'b1;
            end else if (present_next[2]) begin
                selection_next = 2'd2;
                relay_next[2]  = 1'b1;
                start_beep     = 1'b1;
            end
        end else if (present_next[selection_reg]) begin
            relay_next[selection_reg] = 1'b1;
        end else begin
            lost = 1'b1;
        end
        if (lost) begin
            // Release; relays 1 to 3 stay off this tick
            selection_next = acstc_pkg::NO_SOURCE;
        end

        // Start a beep only if none is sounding
        beep_active_next = beep_active_reg;
        beep_left_next   = left_dec;
        if (start_beep && !beep_active_reg) begin
            beep_active_next = 1'b1;
            beep_left_next   = beep_ticks_reg;
        end

        // End of beep
        if (beep_active_next && beep_left_next == '0) begin
            beep_active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg     <= '0;
            selection_reg   <= acstc_pkg::NO_SOURCE;
            beep_active_reg <= 1'b0;
            beep_left_reg   <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < acstc_pkg::NUM_CHANNELS; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (s_accept) begin
                present_reg     <= present_next;
                selection_reg   <= selection_next;
                beep_active_reg <= beep_active_next;
                beep_left_reg   <= beep_left_next;
                for (int i = 0; i < acstc_pkg::NUM_CHANNELS; i++) begin
                    age_reg[i] <= age_next[i];
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until taken; load it with each accepted tick
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            relay_reg <= relay_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_relay_drive     = relay_reg;
    assign m_source_present  = present_reg;
    assign m_selected_source = selection_reg;
    assign m_buzzer_on       = beep_active_reg;

endmodule

// File: rtl/core/acstc_checker.sv
module acstc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_relay_drive,
    input logic [3:0] m_source_present,
    input logic [1:0] m_selected_source,
    input logic       m_buzzer_on
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_relay_drive)
            && $stable(m_source_present) && $stable(m_selected_source)
            && $stable(m_buzzer_on))
        else $error("result changed while stalled");

    // Relays only drive powered channels
    a_relay_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_relay_drive & ~m_source_present) == 4'b0000)
        else $error("relay on for an absent channel");

    // Relay 4 mirrors channel 4
    a_relay4: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_relay_drive[3] == m_source_present[3])
        else $error("relay 4 does not follow channel 4");

    // At most the selected relay among 1 to 3, none without a selection
    a_relay_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_selected_source == acstc_pkg::NO_SOURCE)
                        ? (m_relay_drive[2:0] == 3'b000)
                        : ((m_relay_drive[2:0] & ~(3'b001 << m_selected_source)) == 3'b000)))
        else $error("relays 1 to 3 disagree with selection");

    // All three present forces source 1
    a_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_source_present[2:0] == 3'b111 |-> m_selected_source == 2'd0
            && m_relay_drive[0])
        else $error("source 1 not forced");

endmodule

bind ac_source_transfer_controller_unit acstc_checker u_acstc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_relay_drive     (m_relay_drive),
    .m_source_present  (m_source_present),
    .m_selected_source (m_selected_source),
    .m_buzzer_on       (m_buzzer_on)
);

// File: tb/ac_source_transfer_controller_unit_test.sv
module ac_source_transfer_controller_unit_test;

    localparam int AGE_W        = 16;
    localparam int DRAIN_CYCLES = 4;     // drain margin after the last result is back
    localparam int STALL_LIMIT  = 1000;  // cycles with no request or result taken

    // One tick outcome, field for field as the result port shows it
    typedef struct packed {
        logic [3:0]            relays;
        acstc_pkg::chan_mask_t present;
        logic [1:0]            source;
        logic                  buzzer;
    } tick_outcome_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_index;
    logic [acstc_pkg::CFG_WIDTH-1:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    acstc_pkg::chan_mask_t s_edge_mask;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_relay_drive;
    acstc_pkg::chan_mask_t m_source_present;
    logic [1:0] m_selected_source;
    logic       m_buzzer_on;

    // Shadow registers and shadow state of the controller
    logic [acstc_pkg::CFG_WIDTH-1:0] lim_ticks;
    logic [acstc_pkg::CFG_WIDTH-1:0] beep_len;
    acstc_pkg::chan_mask_t           powered;
    logic [AGE_W-1:0]                age [acstc_pkg::NUM_CHANNELS];
    logic [1:0]                      sel_src;
    logic                            beeping;
    logic [acstc_pkg::CFG_WIDTH-1:0] beep_rem;

    acstc_pkg::chan_mask_t edge_backlog[$];    // tick requests not yet offered
    tick_outcome_t         relay_outcomes[$];  // outcomes of accepted ticks, oldest first

    int idle_pct;                      // chance per cycle of opening an idle burst
    int gap_left;
    int stall_left;
    int edge_pct [acstc_pkg::NUM_CHANNELS];
    int quiet_cycles;
    int results_seen;
    int mismatch_count;

    ac_source_transfer_controller_unit #(.AGE_WIDTH(AGE_W)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_edge_mask       (s_edge_mask),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay_drive     (m_relay_drive),
        .m_source_present  (m_source_present),
        .m_selected_source (m_selected_source),
        .m_buzzer_on       (m_buzzer_on)
    );

    always #2 aclk = ~aclk;

    // Advance the shadow controller by one tick and return what it shows.
    function automatic tick_outcome_t predict_tick(input acstc_pkg::chan_mask_t edge_bits);
        tick_outcome_t outc;
        logic [3:0]    rel;
        logic          picked;
        // age every channel, clear on an edge, drop once the age passes the timeout
        for (int i = 0; i < acstc_pkg::NUM_CHANNELS; i++) begin
            if (age[i] != '1)
                age[i] = age[i] + 1'b1;
            if (edge_bits[i]) begin
                age[i]     = '0;
                powered[i] = 1'b1;
            end
            if (age[i] > lim_ticks)
                powered[i] = 1'b0;
        end
        if (beeping && beep_rem != 0)
            beep_rem = beep_rem - 1'b1;
        rel    = '0;
        rel[3] = powered[3];
        if (powered[2:0] == 3'b111) begin
            // all three up: source 1 wins regardless, and no beep
            sel_src = 2'd0;
            rel[0]  = 1'b1;
        end else if (sel_src == acstc_pkg::NO_SOURCE) begin
            // take the lowest powered source; a running beep is left alone
            picked = 1'b0;
            for (int i = 0; i < 3; i++) begin
                if (!picked && powered[i]) begin
                    picked     = 1'b1;
                    sel_src    = 2'(i);
                    rel[i]     = 1'b1;
                    if (!beeping) begin
                        beeping  = 1'b1;
                        beep_rem = beep_len;
                    end
                end
            end
        end else if (powered[sel_src]) begin
            rel[sel_src] = 1'b1;
        end else begin
            // selected source gone: release it, relays 1 to 3 stay off this tick
            sel_src = acstc_pkg::NO_SOURCE;
        end
        if (beeping && beep_rem == 0)
            beeping = 1'b0;
        outc.relays  = rel;
        outc.present = powered;
        outc.source  = sel_src;
        outc.buzzer  = beeping;
        return outc;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // Request side: hold a request until it is taken, then offer the next one or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                relay_outcomes.push_back(predict_tick(s_edge_mask));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(1, 6) - 1;
                    s_valid  <= 1'b0;
                end else if (edge_backlog.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_edge_mask <= edge_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: stall in bursts while idling is on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (aresetn && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every taken result against the oldest predicted outcome.
    always @(posedge aclk) begin
        tick_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (relay_outcomes.size() == 0) begin
                flag_mismatch("result with no tick request pending");
            end else begin
                want = relay_outcomes.pop_front();
                if (m_relay_drive !== want.relays)
                    flag_mismatch($sformatf("relay_drive %h, expected %h",
                                            m_relay_drive, want.relays));
                if (m_source_present !== want.present)
                    flag_mismatch($sformatf("source_present %h, expected %h",
                                            m_source_present, want.present));
                if (m_selected_source !== want.source)
                    flag_mismatch($sformatf("selected_source %0d, expected %0d",
                                            m_selected_source, want.source));
                if (m_buzzer_on !== want.buzzer)
                    flag_mismatch($sformatf("buzzer_on %b, expected %b",
                                            m_buzzer_on, want.buzzer));
            end
            results_seen++;
        end
    end

    // Watchdog: give up once nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every request is taken and every result is back, then drain.
    task automatic settle();
        @(negedge aclk);
        while (edge_backlog.size() != 0 || s_valid || relay_outcomes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write one register; the shadow copy follows at the same edge.
    task automatic write_reg(input logic idx, input logic [acstc_pkg::CFG_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == acstc_pkg::CFG_LOSS_TIMEOUT)
            lim_ticks = val;
        else
            beep_len = val;
    endtask

    // Queue a directed run of ticks, one hex digit per tick, leftmost first.
    task automatic queue_hex(input logic [63:0] digits, input int count);
        for (int k = count - 1; k >= 0; k--)
            edge_backlog.push_back(digits[4*k +: 4]);
    endtask

    // Queue random ticks: per-channel edge rates, broken by quiet runs that
    // let channels time out when the timeout is short.
    task automatic queue_random(input int count);
        int                    n;
        int                    len;
        acstc_pkg::chan_mask_t m;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, (lim_ticks < 30) ? int'(lim_ticks) + 3 : 12);
                for (int k = 0; k < len; k++)
                    edge_backlog.push_back('0);
                n += len;
            end else begin
                for (int j = 0; j < acstc_pkg::NUM_CHANNELS; j++)
                    m[j] = ($urandom_range(0, 99) < edge_pct[j]);
                edge_backlog.push_back(m);
                n++;
            end
        end
    endtask

    task automatic run_phase(input logic [acstc_pkg::CFG_WIDTH-1:0] lim,
                             input logic [acstc_pkg::CFG_WIDTH-1:0] blen,
                             input int count, input int idle);
        settle();
        write_reg(acstc_pkg::CFG_LOSS_TIMEOUT, lim);
        write_reg(acstc_pkg::CFG_BEEP_TICKS, blen);
        @(negedge aclk);
        idle_pct = idle;
        for (int j = 0; j < acstc_pkg::NUM_CHANNELS; j++)
            edge_pct[j] = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 100);
        queue_random(count);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = acstc_pkg::CFG_LOSS_TIMEOUT;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_edge_mask = '0;
        m_ready     = 1'b0;
        idle_pct    = 0;
        gap_left    = 0;
        stall_left  = 0;
        quiet_cycles   = 0;
        results_seen   = 0;
        mismatch_count = 0;

        // shadow state as after reset
        lim_ticks = acstc_pkg::DEFAULT_TICKS;
        beep_len  = acstc_pkg::DEFAULT_TICKS;
        powered   = '0;
        for (int i = 0; i < acstc_pkg::NUM_CHANNELS; i++)
            age[i] = '0;
        sel_src  = acstc_pkg::NO_SOURCE;
        beeping  = 1'b0;
        beep_rem = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: all three at once forces source 1 with no beep,
        // then single channels including the direct relay 4.
        @(negedge aclk);
        idle_pct = 10;
        queue_hex(64'hF018, 4);

        // Shortest timeout: take a source, lose it (relays off for the tick),
        // pick another while the beep still sounds, force source 1, drop all.
        settle();
        write_reg(acstc_pkg::CFG_LOSS_TIMEOUT, 16'd1);
        write_reg(acstc_pkg::CFG_BEEP_TICKS, 16'd3);
        @(negedge aclk);
        queue_hex(64'h021111773088F400, 16);

        // Zero-length beep: the buzzer never comes on.
        settle();
        write_reg(acstc_pkg::CFG_BEEP_TICKS, 16'd0);
        @(negedge aclk);
        queue_hex(64'h44001, 5);

        // Timeout at the top of the range: channels seen once stay present.
        settle();
        write_reg(acstc_pkg::CFG_LOSS_TIMEOUT, 16'hFFFF);
        @(negedge aclk);
        idle_pct = 0;
        edge_backlog.push_back(4'hF);
        for (int k = 0; k < 40; k++)
            edge_backlog.push_back('0);

        // Random phases across a spread of settings, extremes included.
        run_phase(16'd1,     16'd1,     150, 10);
        run_phase(16'd2,     16'hFFFF,  150, 30);
        run_phase(16'd3,     16'd2,     200, 0);
        run_phase(16'd6,     16'd9,     200, 20);
        run_phase(16'd20,    16'd40,    200, 10);
        run_phase(16'hFFFE,  16'd100,   150, 20);
        run_phase(16'd4,     16'd1,     200, 30);
        run_phase(16'd1,     16'd5,     150, 10);
        // last stretch at full rate on both sides
        run_phase(16'd2,     16'd3,     150, 0);

        settle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
